>>> sv/qdpr_pkg.sv
package qdpr_pkg;

  localparam int ACC_BITS = 64;

  // Operand differences and their product
  localparam int BYTE_W = 8;
  localparam int DIFF_W = BYTE_W + 1;
  localparam int PROD_W = 2 * DIFF_W;

  // Requantization datapath
  localparam int MULT_W   = 32;
  localparam int SHIFT_W  = 6;
  localparam int HI_W     = ACC_BITS - MULT_W;
  localparam int SCALED_W = ACC_BITS + MULT_W;
  localparam int SIDX_W   = $clog2(SCALED_W);
  localparam int MAG_CAP  = 1000;
  localparam int MAG_W    = $clog2(MAG_CAP + 1);
  // The capped magnitude plus a signed byte offset needs two more bits.
  localparam int VAL_W    = MAG_W + 2;
  localparam int RAW_W    = 32;

  // Decoupling queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_IS_SIGNED      = 3'd0,
    REG_B_IS_SIGNED      = 3'd1,
    REG_OUT_IS_SIGNED    = 3'd2,
    REG_SCALE_MULTIPLIER = 3'd3,
    REG_SCALE_SHIFT      = 3'd4,
    REG_OUTPUT_ZERO      = 3'd5
  } cfg_reg_t;

  localparam logic [MULT_W-1:0]  SCALE_MULT_RESET  = 32'h8000_0000;
  localparam logic [SHIFT_W-1:0] SCALE_SHIFT_RESET = 6'd31;

  typedef struct packed {
    logic              out_is_signed;
    logic [MULT_W-1:0]  scale_multiplier;
    logic [SHIFT_W-1:0] scale_shift;
    logic [BYTE_W-1:0]  output_zero;
  } quant_cfg_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] prod;
    logic                     last;
  } fifo_entry_t;

  typedef enum logic [2:0] {
    S_ACC,
    S_MAG,
    S_MUL0,
    S_MUL1,
    S_SUM,
    S_SHIFT,
    S_RND,
    S_FIN
  } back_state_t;

  // Reads a raw byte as int8 or uint8.
  function automatic logic signed [DIFF_W-1:0] read_byte(input logic [BYTE_W-1:0] raw,
                                                         input logic is_signed);
    read_byte = is_signed ? {raw[BYTE_W-1], raw} : {1'b0, raw};
  endfunction

endpackage

>>> sv/qdpr_front.sv
module qdpr_front (
  input  logic [qdpr_pkg::BYTE_W-1:0]         a_byte,
  input  logic [qdpr_pkg::BYTE_W-1:0]         b_byte,
  input  logic [qdpr_pkg::BYTE_W-1:0]         a_zero,
  input  logic [qdpr_pkg::BYTE_W-1:0]         b_zero,
  input  logic                                last,
  input  logic                                a_is_signed,
  input  logic                                b_is_signed,
  output qdpr_pkg::fifo_entry_t               entry
);
  import qdpr_pkg::*;

  logic signed [DIFF_W-1:0] a_diff;
  logic signed [DIFF_W-1:0] b_diff;

  // Both differences fit in nine bits whatever the signedness mix.
  assign a_diff = read_byte(a_byte, a_is_signed) - read_byte(a_zero, a_is_signed);
  assign b_diff = read_byte(b_byte, b_is_signed) - read_byte(b_zero, b_is_signed);

  assign entry.prod = PROD_W'(a_diff) * PROD_W'(b_diff);
  assign entry.last = last;

endmodule

>>> sv/qdpr_fifo.sv
module qdpr_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  qdpr_pkg::fifo_entry_t wr_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output qdpr_pkg::fifo_entry_t rd_data
);
  import qdpr_pkg::*;

  fifo_entry_t             mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r;
  logic [FIFO_PTR_W-1:0]   wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r;
  logic [FIFO_PTR_W-1:0]   rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]   count_r;
  logic [FIFO_CNT_W-1:0]   count_nxt;
  logic                    do_push;
  logic                    do_pop;

  assign full      = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign rd_data   = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(do_push);
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(do_pop);
    count_nxt  = count_r + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> sv/qdpr_back.sv
module qdpr_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  qdpr_pkg::quant_cfg_t                cfg,
  input  logic                                entry_valid,
  input  qdpr_pkg::fifo_entry_t               entry,
  output logic                                entry_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [qdpr_pkg::RAW_W-1:0]   out_raw_sum,
  output logic [qdpr_pkg::BYTE_W-1:0]         out_quantized,
  output logic                                out_saturated
);
  import qdpr_pkg::*;

  back_state_t               state_r;
  back_state_t               state_nxt;
  logic [ACC_BITS-1:0]       acc_r;
  logic [ACC_BITS-1:0]       acc_nxt;
  logic [ACC_BITS-1:0]       acc_sum;
  logic [ACC_BITS-1:0]       sum_r;
  logic [ACC_BITS-1:0]       sum_nxt;
  logic                      neg_r;
  logic                      neg_nxt;
  logic [ACC_BITS-1:0]       mag_r;
  logic [ACC_BITS-1:0]       mag_nxt;
  logic [2*MULT_W-1:0]       p0_r;
  logic [2*MULT_W-1:0]       p0_nxt;
  logic [HI_W+MULT_W-1:0]    p1_r;
  logic [HI_W+MULT_W-1:0]    p1_nxt;
  logic [SCALED_W-1:0]       scaled_r;
  logic [SCALED_W-1:0]       scaled_nxt;
  logic [SCALED_W-1:0]       q_r;
  logic [SCALED_W-1:0]       q_nxt;
  logic                      round_up_r;
  logic                      round_up_nxt;
  logic [SIDX_W-1:0]         guard_idx;
  logic [SCALED_W-1:0]       sticky_mask;
  logic [MAG_W-1:0]          mag_c;
  logic signed [VAL_W-1:0]   zp;
  logic signed [VAL_W-1:0]   val;
  logic signed [VAL_W-1:0]   lo_b;
  logic signed [VAL_W-1:0]   hi_b;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic [RAW_W-1:0]          raw_r;
  logic [RAW_W-1:0]          raw_nxt;
  logic [BYTE_W-1:0]         quant_r;
  logic [BYTE_W-1:0]         quant_nxt;
  logic                      sat_r;
  logic                      sat_nxt;
  logic                      out_free;

  assign acc_sum   = acc_r + {{(ACC_BITS-PROD_W){entry.prod[PROD_W-1]}}, entry.prod};
  assign out_free  = !out_valid_r || out_ready;
  assign guard_idx = SIDX_W'(cfg.scale_shift) - SIDX_W'(1);
  assign sticky_mask = (SCALED_W'(1) << guard_idx) - SCALED_W'(1);

  assign out_valid     = out_valid_r;
  assign out_raw_sum   = raw_r;
  assign out_quantized = quant_r;
  assign out_saturated = sat_r;

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    sum_nxt       = sum_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    p0_nxt        = p0_r;
    p1_nxt        = p1_r;
    scaled_nxt    = scaled_r;
    q_nxt         = q_r;
    round_up_nxt  = round_up_r;
    raw_nxt       = raw_r;
    quant_nxt     = quant_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    entry_pop     = 1'b0;

    // The final value: capped magnitude, signed, offset, then clamped.
    if (q_r > SCALED_W'(MAG_CAP)) begin
      mag_c = MAG_W'(MAG_CAP);
    end else begin
      mag_c = q_r[MAG_W-1:0];
    end
    zp   = VAL_W'(read_byte(cfg.output_zero, cfg.out_is_signed));
    val  = neg_r ? (zp - VAL_W'(mag_c)) : (zp + VAL_W'(mag_c));
    lo_b = cfg.out_is_signed ? -VAL_W'(128) : VAL_W'(0);
    hi_b = cfg.out_is_signed ? VAL_W'(127) : VAL_W'(255);

    case (state_r)
      S_ACC: begin
        entry_pop = entry_valid;
        if (entry_valid) begin
          if (entry.last) begin
            sum_nxt   = acc_sum;
            acc_nxt   = '0;
            state_nxt = S_MAG;
          end else begin
            acc_nxt = acc_sum;
          end
        end
      end
      S_MAG: begin
        neg_nxt   = sum_r[ACC_BITS-1];
        mag_nxt   = sum_r[ACC_BITS-1] ? (~sum_r + ACC_BITS'(1)) : sum_r;
        state_nxt = S_MUL0;
      end
      S_MUL0: begin
        p0_nxt    = (2*MULT_W)'(mag_r[MULT_W-1:0]) * (2*MULT_W)'(cfg.scale_multiplier);
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        p1_nxt    = (HI_W+MULT_W)'(mag_r[ACC_BITS-1:MULT_W]) *
                    (HI_W+MULT_W)'(cfg.scale_multiplier);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        scaled_nxt = {p1_r, {MULT_W{1'b0}}} + SCALED_W'(p0_r);
        state_nxt  = S_SHIFT;
      end
      S_SHIFT: begin
        // Round half to even: guard bit set and either sticky bits or an odd quotient.
        q_nxt        = scaled_r >> cfg.scale_shift;
        round_up_nxt = (cfg.scale_shift != '0) && scaled_r[guard_idx] &&
                       ((|(scaled_r & sticky_mask)) || q_nxt[0]);
        state_nxt    = S_RND;
      end
      S_RND: begin
        q_nxt     = q_r + SCALED_W'(round_up_r);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          raw_nxt       = sum_r[RAW_W-1:0];
          out_valid_nxt = 1'b1;
          if (val < lo_b) begin
            quant_nxt = lo_b[BYTE_W-1:0];
            sat_nxt   = 1'b1;
          end else if (val > hi_b) begin
            quant_nxt = hi_b[BYTE_W-1:0];
            sat_nxt   = 1'b1;
          end else begin
            quant_nxt = val[BYTE_W-1:0];
            sat_nxt   = 1'b0;
          end
          state_nxt = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r      <= sum_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    p0_r       <= p0_nxt;
    p1_r       <= p1_nxt;
    scaled_r   <= scaled_nxt;
    q_r        <= q_nxt;
    round_up_r <= round_up_nxt;
    raw_r      <= raw_nxt;
    quant_r    <= quant_nxt;
    sat_r      <= sat_nxt;
  end

endmodule

>>> sv/quantized_dot_product_requantize_top.sv
// A word with last set passes the queue registers and then the back-end states S_MAG,
// S_MUL0, S_MUL1, S_SUM, S_SHIFT, S_RND and S_FIN before its result is registered.
// Throughput: one word per cycle while accumulating and the queue has room; each word
// with last set holds the accumulator through S_FIN, as the requantization shares its
// state machine. Reset (synchronous, active low) empties the queue, clears the
// accumulator and out_valid, and returns every configuration register to its default.
module quantized_dot_product_requantize_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [qdpr_pkg::BYTE_W-1:0]         in_a_byte,
  input  logic [qdpr_pkg::BYTE_W-1:0]         in_b_byte,
  input  logic [qdpr_pkg::BYTE_W-1:0]         in_a_zero,
  input  logic [qdpr_pkg::BYTE_W-1:0]         in_b_zero,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [qdpr_pkg::RAW_W-1:0]   out_raw_sum,
  output logic [qdpr_pkg::BYTE_W-1:0]         out_quantized,
  output logic                                out_saturated,
  input  logic                                cfg_we,
  input  logic [qdpr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qdpr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import qdpr_pkg::*;

  logic         a_is_signed_r;
  logic         b_is_signed_r;
  quant_cfg_t   qcfg_r;
  fifo_entry_t  front_entry;
  fifo_entry_t  back_entry;
  logic         fifo_full;
  logic         fifo_not_empty;
  logic         fifo_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_is_signed_r           <= 1'b0;
      b_is_signed_r           <= 1'b0;
      qcfg_r.out_is_signed    <= 1'b0;
      qcfg_r.scale_multiplier <= SCALE_MULT_RESET;
      qcfg_r.scale_shift      <= SCALE_SHIFT_RESET;
      qcfg_r.output_zero      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_A_IS_SIGNED:      a_is_signed_r           <= cfg_wdata[0];
        REG_B_IS_SIGNED:      b_is_signed_r           <= cfg_wdata[0];
        REG_OUT_IS_SIGNED:    qcfg_r.out_is_signed    <= cfg_wdata[0];
        REG_SCALE_MULTIPLIER: qcfg_r.scale_multiplier <= cfg_wdata[MULT_W-1:0];
        REG_SCALE_SHIFT:      qcfg_r.scale_shift      <= cfg_wdata[SHIFT_W-1:0];
        REG_OUTPUT_ZERO:      qcfg_r.output_zero      <= cfg_wdata[BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !fifo_full;

  qdpr_front u_front (
    .a_byte      (in_a_byte),
    .b_byte      (in_b_byte),
    .a_zero      (in_a_zero),
    .b_zero      (in_b_zero),
    .last        (in_last),
    .a_is_signed (a_is_signed_r),
    .b_is_signed (b_is_signed_r),
    .entry       (front_entry)
  );

  qdpr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .wr_data   (front_entry),
    .full      (fifo_full),
    .pop       (fifo_pop),
    .not_empty (fifo_not_empty),
    .rd_data   (back_entry)
  );

  qdpr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (qcfg_r),
    .entry_valid   (fifo_not_empty),
    .entry         (back_entry),
    .entry_pop     (fifo_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_raw_sum   (out_raw_sum),
    .out_quantized (out_quantized),
    .out_saturated (out_saturated)
  );

endmodule

>>> sv/qdpr_checker.sv
module qdpr_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [qdpr_pkg::RAW_W-1:0]   out_raw_sum,
  input logic [qdpr_pkg::BYTE_W-1:0]         out_quantized,
  input logic                                out_saturated
);

  // A reset cycle always leaves the output empty.
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word still valid after reset");

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_raw_sum) &&
                                $stable(out_quantized) && $stable(out_saturated))
    else $error("stalled output word changed");

  // A clamped result sits on one of the output range limits.
  a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_quantized == 8'h00 || out_quantized == 8'hFF ||
                                   out_quantized == 8'h80 || out_quantized == 8'h7F)
    else $error("saturated output is not at a range limit");

  // The queue is empty right after a reset cycle, so the input is ready.
  a_ready_after_reset: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind quantized_dot_product_requantize_top qdpr_checker u_qdpr_checker (.*);
